// File: rtl/core/prl_pkg.sv
// Package of shared types and constants for the positional record list.
package prl_pkg;

    localparam int POS_W   = 6;
    localparam int TEXT_W  = 64;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_RETRIEVE = 2'd2,
        OP_SEARCH   = 2'd3
    } t_opcode;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_BADPOS    = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        t_opcode              opcode;
        logic [POS_W-1:0]     position;
        logic signed [31:0]   employee_id;
        logic [TEXT_W-1:0]    name_text;
        logic [TEXT_W-1:0]    address_text;
        logic [TEXT_W-1:0]    manager_text;
        logic [31:0]          salary_bits;
        logic [TEXT_W-1:0]    search_text;
    } t_in;

    typedef struct packed {
        logic [2:0]           status;
        logic [POS_W-1:0]     result_position;
        logic signed [31:0]   out_employee_id;
        logic [TEXT_W-1:0]    out_name;
        logic [TEXT_W-1:0]    out_address;
        logic [TEXT_W-1:0]    out_manager;
        logic [31:0]          out_salary;
        logic [COUNT_W-1:0]   entry_count;
        logic                 is_empty;
        logic                 is_full;
    } t_out;

    typedef struct packed {
        logic [31:0]          id;
        logic [TEXT_W-1:0]    name;
        logic [TEXT_W-1:0]    addr;
        logic [TEXT_W-1:0]    mgr;
        logic [31:0]          salary;
    } t_rec;

    localparam t_rec REC_ZERO    = '{id: 32'd0, name: 64'd0, addr: 64'd0, mgr: 64'd0,
                                     salary: 32'd0};
    localparam t_rec REC_DEFAULT = '{id: 32'd0, name: 64'h20, addr: 64'h20, mgr: 64'h20,
                                     salary: 32'd0};

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_FLUSH,
        S_INS_NEW,
        S_DEL_SHIFT,
        S_DEL_FLUSH,
        S_RD_WAIT,
        S_SEARCH,
        S_DONE
    } t_state;

endpackage

// File: rtl/core/prl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module prl_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/positional_record_list_top.sv
// Top level of the positional record list: sequencer around one record RAM.
//
// Usage: one input word per operation on i_valid/o_stall (insert, delete,
// retrieve or search), one result word per operation on o_valid/i_stall.
// Records sit contiguously in one RAM of CAPACITY entries with one read and
// one write port; only entries below the count are ever read.
// Work per operation from acceptance to the result register:
//   insert:   entries from the top down to the position move up one place,
//             then the new record is written; at the end only the write
//   delete:   entries above the position move down one place; none when
//             the last entry goes
//   retrieve: one read of the entry at the position
//   search:   records are read from index 0 until the first match or the
//             count; an empty list reads none
//   rejected operations (full, empty, bad position): straight to the result
// o_stall is high from acceptance until the result is registered. The RAM sets
// the pace: its read data is registered and one comparator looks at one record a cycle.
// A stalled result holds steady in the output register; the next operation may
// be accepted and worked on meanwhile, finishing only once the register is free.
// Reset clears the count, the sequencer and the output valid; the RAM
// contents are not cleared and need no clearing pass.
module positional_record_list_top
    import prl_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int TEXT_BYTES = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_stall,
    output logic o_valid,
    output t_out o_data,
    input  logic i_stall
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [TEXT_W-1:0] TEXT_MASK = {TEXT_W{1'b1}} >> (TEXT_W - 8 * TEXT_BYTES);

    t_state          r_state, n_state;
    t_in             r_req, n_req;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_count, n_count;
    logic            r_pend, n_pend;
    logic [AW-1:0]   r_waddr, n_waddr;
    logic [2:0]      r_status, n_status;
    t_rec            r_rec, n_rec;
    t_out            r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    t_rec            ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    t_rec            ram_rdata;

    logic [XW-1:0]   pos_x;
    logic [XW-1:0]   cnt_x;
    logic [XW-1:0]   idx_x;
    logic            key_match;
    logic            out_free;
    t_in             in_bounded;

    prl_ram #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        in_bounded              = i_data;
        in_bounded.name_text    = i_data.name_text & TEXT_MASK;
        in_bounded.address_text = i_data.address_text & TEXT_MASK;
        in_bounded.manager_text = i_data.manager_text & TEXT_MASK;
        in_bounded.search_text  = i_data.search_text & TEXT_MASK;
    end

    // In IDLE the checks look at the incoming word, later at the held one.
    assign pos_x = XW'((r_state == S_IDLE) ? i_data.position : r_req.position);
    assign cnt_x = XW'(r_count);
    assign idx_x = XW'(r_idx);

    // The one comparator: the record read last cycle against the search key.
    assign key_match = (ram_rdata.name == r_req.search_text) ||
                       (ram_rdata.addr == r_req.search_text) ||
                       (ram_rdata.mgr  == r_req.search_text);

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_waddr  <= n_waddr;
        r_status <= n_status;
        r_rec    <= n_rec;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_idx       = r_idx;
        n_count     = r_count;
        n_pend      = 1'b0;
        n_waddr     = r_waddr;
        n_status    = r_status;
        n_rec       = r_rec;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;

        ram_we    = 1'b0;
        ram_waddr = r_waddr;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req    = in_bounded;
                    n_status = ST_OK;
                    n_rec    = REC_ZERO;
                    n_waddr  = '0;
                    n_state  = S_DONE;
                    unique case (i_data.opcode)
                        OP_INSERT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else if (pos_x > cnt_x) begin
                                n_status = ST_BADPOS;
                            end else if (cnt_x > pos_x) begin
                                n_idx   = r_count - CW'(1);
                                n_state = S_INS_SHIFT;
                            end else begin
                                n_state = S_INS_NEW;
                            end
                        end
                        OP_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (pos_x >= cnt_x) begin
                                n_status = ST_BADPOS;
                            end else if (pos_x + XW'(1) < cnt_x) begin
                                n_idx   = CW'(i_data.position) + CW'(1);
                                n_state = S_DEL_SHIFT;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        OP_RETRIEVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_rec    = REC_DEFAULT;
                            end else if (pos_x >= cnt_x) begin
                                n_status = ST_BADPOS;
                                n_rec    = REC_DEFAULT;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = AW'(i_data.position);
                                n_state   = S_RD_WAIT;
                            end
                        end
                        OP_SEARCH: begin
                            n_status = ST_NOT_FOUND;
                            n_idx    = '0;
                            n_state  = S_SEARCH;
                        end
                    endcase
                end
            end
            S_INS_SHIFT: begin
                // Read entry idx while the entry read last cycle lands one place up.
                ram_we  = r_pend;
                ram_re  = 1'b1;
                n_pend  = 1'b1;
                n_waddr = r_idx[AW-1:0] + AW'(1);
                if (idx_x == pos_x) begin
                    n_state = S_INS_FLUSH;
                end else begin
                    n_idx = r_idx - CW'(1);
                end
            end
            S_INS_FLUSH: begin
                ram_we  = r_pend;
                n_state = S_INS_NEW;
            end
            S_INS_NEW: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_req.position);
                ram_wdata = '{id: r_req.employee_id, name: r_req.name_text,
                              addr: r_req.address_text, mgr: r_req.manager_text,
                              salary: r_req.salary_bits};
                n_count   = r_count + CW'(1);
                n_state   = S_DONE;
            end
            S_DEL_SHIFT: begin
                ram_we  = r_pend;
                ram_re  = 1'b1;
                n_pend  = 1'b1;
                n_waddr = r_idx[AW-1:0] - AW'(1);
                if (r_idx == r_count - CW'(1)) begin
                    n_state = S_DEL_FLUSH;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_DEL_FLUSH: begin
                ram_we  = r_pend;
                n_count = r_count - CW'(1);
                n_state = S_DONE;
            end
            S_RD_WAIT: begin
                n_rec   = ram_rdata;
                n_state = S_DONE;
            end
            S_SEARCH: begin
                // r_waddr holds the index of the record now on the read port.
                if (r_pend && key_match) begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else if (r_idx < r_count) begin
                    ram_re  = 1'b1;
                    n_pend  = 1'b1;
                    n_waddr = r_idx[AW-1:0];
                    n_idx   = r_idx + CW'(1);
                end else if (!r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.status          = r_status;
                    n_out.result_position = (r_status == ST_OK && r_req.opcode == OP_SEARCH)
                                            ? POS_W'(r_waddr) : '0;
                    n_out.out_employee_id = r_rec.id;
                    n_out.out_name        = r_rec.name;
                    n_out.out_address     = r_rec.addr;
                    n_out.out_manager     = r_rec.mgr;
                    n_out.out_salary      = r_rec.salary;
                    n_out.entry_count     = COUNT_W'(r_count);
                    n_out.is_empty        = (r_count == '0);
                    n_out.is_full         = (r_count == CW'(CAPACITY));
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// File: rtl/core/prl_checker.sv
// Port-level checker for the positional record list, bound to the top level.
module prl_checker
    import prl_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input t_out o_data,
    input logic i_stall
);

    // No result word may appear straight out of reset.
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result word valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result word changed");

    // Every accepted word moves the sequencer out of IDLE, so it blocks the next one.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken on consecutive cycles");

    a_flags_match_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.is_empty == (o_data.entry_count == '0)) &&
                    (o_data.is_full == (o_data.entry_count == COUNT_W'(CAPACITY))))
        else $error("empty or full flag disagrees with entry count");

endmodule

bind positional_record_list_top prl_checker #(.CAPACITY(CAPACITY)) u_prl_checker (.*);
